>>> rtl/smf_pkg.sv
// Shared constants and types of the sliding median filter.
package smf_pkg;

   localparam int WINDOW      = 5;
   localparam int CHANNELS    = 2;
   localparam int SAMPLE_BITS = 12;

   localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FILL_BITS = $clog2(WINDOW + 1);

   typedef logic [SAMPLE_BITS-1:0]   sample_type;
   typedef sample_type [WINDOW-1:0]  window_type;
   typedef logic [FILL_BITS-1:0]     fill_type;
   typedef logic [CH_BITS-1:0]       chan_type;

endpackage

>>> rtl/smf_cell.sv
// One window cell: holds the sample of a given age for every channel.
module smf_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  smf_pkg::chan_type   channel,
   input  smf_pkg::sample_type data_in,
   output smf_pkg::sample_type data_out
);

   smf_pkg::sample_type store_ff [smf_pkg::CHANNELS];

   always_ff @(posedge clock) begin
      if (shift_en) begin
         store_ff[channel] <= data_in;
      end
   end

   assign data_out = store_ff[channel];

endmodule

>>> rtl/smf_select.sv
// Rank-based median pick over the valid entries of one window.
module smf_select (
   input  smf_pkg::window_type window,
   input  smf_pkg::fill_type   fill,
   output smf_pkg::sample_type median
);

   smf_pkg::fill_type rank [smf_pkg::WINDOW];
   smf_pkg::fill_type half;

   assign half = smf_pkg::fill_type'(fill >> 1);

   always_comb begin
      for (int i = 0; i < smf_pkg::WINDOW; i++) begin
         rank[i] = '0;
         for (int j = 0; j < smf_pkg::WINDOW; j++) begin
            if (smf_pkg::fill_type'(j) < fill && j != i &&
                ((window[j] < window[i]) || (window[j] == window[i] && j < i))) begin
               rank[i] = rank[i] + smf_pkg::fill_type'(1);
            end
         end
      end
   end

   always_comb begin
      median = '0;
      for (int i = 0; i < smf_pkg::WINDOW; i++) begin
         if (smf_pkg::fill_type'(i) < fill && rank[i] == half) begin
            median = median | window[i];
         end
      end
   end

endmodule

>>> rtl/sliding_median_filter_top.sv
// Sliding median filter: per-channel shift window of cells and a rank-select median.
// Pipeline: a request transfer is registered as the window capture, then the median pick is registered for rsp_valid.
// Throughput: one sample per cycle while rsp_ready does not stall the output; the cell row shifts on every transfer.
// Reset clears the per-channel fill counts and both pipeline valid flags.
// Sample cells are not reset; entries beyond the fill count never reach the result.
module sliding_median_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [0:0]  req_channel,
   input  logic [11:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_median
);

   smf_pkg::chan_type   ch;
   smf_pkg::sample_type new_sample;
   smf_pkg::window_type win_in;
   smf_pkg::sample_type cell_q [smf_pkg::WINDOW];
   smf_pkg::fill_type   fill_ff [smf_pkg::CHANNELS];
   smf_pkg::fill_type   fill_in;
   smf_pkg::fill_type   fill_cur;
   smf_pkg::window_type s1_win_ff;
   smf_pkg::fill_type   s1_fill_ff;
   logic                s1_valid_ff;
   logic                rsp_valid_ff;
   smf_pkg::sample_type median_ff;
   smf_pkg::sample_type median_in;
   logic                accept;
   logic                out_free;
   logic                s1_move;

   assign ch         = smf_pkg::chan_type'(32'(req_channel) % smf_pkg::CHANNELS);
   assign new_sample = smf_pkg::sample_type'(req_sample);
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;

   for (genvar k = 0; k < smf_pkg::WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign win_in[k] = new_sample;
      end else begin : g_body
         assign win_in[k] = cell_q[k-1];
      end
      smf_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .channel  (ch),
         .data_in  (win_in[k]),
         .data_out (cell_q[k])
      );
   end

   assign fill_cur = fill_ff[ch];
   assign fill_in  = (fill_cur < smf_pkg::fill_type'(smf_pkg::WINDOW)) ?
                     fill_cur + smf_pkg::fill_type'(1) :
                     smf_pkg::fill_type'(smf_pkg::WINDOW);

   smf_select u_select (
      .window (s1_win_ff),
      .fill   (s1_fill_ff),
      .median (median_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < smf_pkg::CHANNELS; c++) begin
            fill_ff[c] <= '0;
         end
      end else begin
         if (accept) begin
            fill_ff[ch] <= fill_in;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_win_ff  <= win_in;
         s1_fill_ff <= fill_in;
      end
      if (s1_move) begin
         median_ff <= median_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = 12'(median_ff);

endmodule
